@@ design/pip_pkg.sv @@
// ---------------------------------------------------------------------------
// pip_pkg
// Shared constants, codes and controller/datapath interface types for the
// point-in-polygon test.
// ---------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int COORD_WIDTH  = 16;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int COUNT_W      = 5;
   localparam int INDEX_W      = 4;
   localparam int FIELD_W      = 16;
   localparam int DIFF_W       = COORD_WIDTH + 1;
   localparam int PROD_W       = 2 * DIFF_W;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic              clear;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              first;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic done;
   } sts_type;

endpackage

`default_nettype wire

@@ design/point_in_polygon_test.sv @@
// ---------------------------------------------------------------------------
// point_in_polygon_test
// Ray casting point-in-polygon test over a stored polygon of up to
// MAX_VERTICES vertices.
//
//   channel   ports                                     handshake
//   request   req_opcode req_vertex_index req_coord_*   start & !busy
//   response  rsp_inside_res                            rsp_valid strobe
//   csr       csr_wdata (vertex_count)                  csr_valid & csr_ready
//
// A vertex write leaves busy low.
// A query over n vertices holds busy while the walk reads the vertex store,
// one read a cycle for n+1 reads, then three pipeline stages and a done flag.
// The result strobes in the first cycle with busy low again; with no vertices
// it strobes in the cycle after the request, busy staying low.
// Reset is synchronous and clears the count; the receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_opcode,
   input  wire logic [pip_pkg::INDEX_W-1:0]     req_vertex_index,
   input  wire logic [pip_pkg::FIELD_W-1:0]     req_coord_x,
   input  wire logic [pip_pkg::FIELD_W-1:0]     req_coord_y,
   output logic                                 rsp_valid,
   output logic                                 rsp_inside_res,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pip_pkg::COUNT_W-1:0]     csr_wdata
);
   import pip_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pip_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_vertex_index (req_vertex_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .cmd              (cmd),
      .sts              (sts)
   );

   pip_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .inside_res  (rsp_inside_res)
   );

endmodule

`default_nettype wire

@@ design/pip_ctrl.sv @@
// ---------------------------------------------------------------------------
// pip_ctrl
// Request handshake, vertex count register and edge walk sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module pip_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_opcode,
   input  wire logic [pip_pkg::INDEX_W-1:0]     req_vertex_index,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pip_pkg::COUNT_W-1:0]     csr_wdata,
   output logic                                 rsp_valid,
   output pip_pkg::cmd_type                     cmd,
   input  wire pip_pkg::sts_type                sts
);
   import pip_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_WAIT} state_type;

   state_type          state_ff;
   logic               busy_ff;
   logic               rsp_valid_ff;
   logic               first_ff;
   logic [ADDR_W-1:0]  idx_ff;
   logic [ADDR_W-1:0]  nm1_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] n_eff;
   logic               accept;
   logic               query;
   logic               last_rd;

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

   assign accept  = start && !busy_ff;
   assign query   = accept && (req_opcode == OP_QUERY);
   assign n_eff   = (count_ff > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES) : count_ff;
   assign last_rd = !first_ff && (idx_ff == nm1_ff);

   assign count_in = (csr_valid && csr_ready) ? csr_wdata : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      cmd.clear   = query;
      cmd.wr_en   = accept && (req_opcode == OP_WRITE);
      cmd.wr_addr = req_vertex_index[ADDR_W-1:0];
      cmd.rd_en   = (state_ff == ST_WALK);
      cmd.rd_addr = first_ff ? nm1_ff : idx_ff;
      cmd.first   = first_ff;
      cmd.last    = (state_ff == ST_WALK) && last_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         idx_ff       <= '0;
         nm1_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (query) begin
                  if (n_eff == '0) begin
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_WALK;
                     busy_ff  <= 1'b1;
                     first_ff <= 1'b1;
                     idx_ff   <= '0;
                     nm1_ff   <= ADDR_W'(n_eff - COUNT_W'(1));
                  end
               end
            end
            ST_WALK: begin
               if (first_ff) begin
                  first_ff <= 1'b0;
               end else if (last_rd) begin
                  state_ff <= ST_WAIT;
               end else begin
                  idx_ff <= idx_ff + ADDR_W'(1);
               end
            end
            ST_WAIT: begin
               if (sts.done) begin
                  state_ff     <= ST_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> busy_ff)
      else $error("walk active without busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (state_ff == ST_WAIT))
      else $error("datapath done outside wait");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.wr_en)
      else $error("vertex write during walk");

   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      (query && (n_eff == '0)) |=> (rsp_valid_ff && !busy_ff))
      else $error("empty polygon query gave no result");
`endif

endmodule

`default_nettype wire

@@ design/pip_datapath.sv @@
// ---------------------------------------------------------------------------
// pip_datapath
// Vertex store and pipelined edge crossing test with inside flag.
// ---------------------------------------------------------------------------
`default_nettype none

module pip_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pip_pkg::cmd_type                cmd,
   output pip_pkg::sts_type                     sts,
   input  wire logic [pip_pkg::FIELD_W-1:0]     req_coord_x,
   input  wire logic [pip_pkg::FIELD_W-1:0]     req_coord_y,
   output logic                                 inside_res
);
   import pip_pkg::*;

   logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];

   logic signed [COORD_WIDTH-1:0] px_ff, py_ff;
   logic signed [COORD_WIDTH-1:0] rd_x_ff, rd_y_ff;
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff;
   logic                          s1_vld_ff, s1_first_ff, s1_last_ff;

   logic signed [DIFF_W-1:0]      px_e, py_e, xi_e, yi_e, xj_e, yj_e;
   logic signed [DIFF_W-1:0]      dxi_ff, dy_ff, dxji_ff, dyi_ff;
   logic                          s2_vld_ff, s2_last_ff, s2_cross_ff;

   logic signed [PROD_W-1:0]      p1_ff, p2_ff;
   logic                          s3_vld_ff, s3_last_ff, s3_cross_ff, s3_neg_ff;

   logic                          hit;
   logic                          inside_ff, inside_in;
   logic                          done_ff;

   assign sts.done   = done_ff;
   assign inside_res = inside_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_x[cmd.wr_addr] <= req_coord_x[COORD_WIDTH-1:0];
         mem_y[cmd.wr_addr] <= req_coord_y[COORD_WIDTH-1:0];
      end
      if (cmd.rd_en) begin
         rd_x_ff <= mem_x[cmd.rd_addr];
         rd_y_ff <= mem_y[cmd.rd_addr];
      end
      if (cmd.clear) begin
         px_ff <= req_coord_x[COORD_WIDTH-1:0];
         py_ff <= req_coord_y[COORD_WIDTH-1:0];
      end
   end

   assign px_e = DIFF_W'(px_ff);
   assign py_e = DIFF_W'(py_ff);
   assign xi_e = DIFF_W'(rd_x_ff);
   assign yi_e = DIFF_W'(rd_y_ff);
   assign xj_e = DIFF_W'(prev_x_ff);
   assign yj_e = DIFF_W'(prev_y_ff);

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
      dxi_ff      <= px_e - xi_e;
      dy_ff       <= yj_e - yi_e;
      dxji_ff     <= xj_e - xi_e;
      dyi_ff      <= py_e - yi_e;
      s2_cross_ff <= (rd_y_ff > py_ff) != (prev_y_ff > py_ff);
      p1_ff       <= PROD_W'(dxi_ff) * PROD_W'(dy_ff);
      p2_ff       <= PROD_W'(dxji_ff) * PROD_W'(dyi_ff);
      s3_cross_ff <= s2_cross_ff;
      s3_neg_ff   <= dy_ff[DIFF_W-1];
      s2_last_ff  <= s1_last_ff;
      s3_last_ff  <= s2_last_ff;
   end

   assign hit       = s3_cross_ff && (s3_neg_ff ? (p1_ff > p2_ff) : (p1_ff < p2_ff));
   assign inside_in = cmd.clear ? 1'b0 : (inside_ff ^ (s3_vld_ff && hit));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s1_first_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
         inside_ff   <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_vld_ff   <= cmd.rd_en;
         s1_first_ff <= cmd.first;
         s1_last_ff  <= cmd.last;
         s2_vld_ff   <= s1_vld_ff && !s1_first_ff;
         s3_vld_ff   <= s2_vld_ff;
         inside_ff   <= inside_in;
         done_ff     <= s3_vld_ff && s3_last_ff;
      end
   end

endmodule

`default_nettype wire
